@@ rtl/owsp_pkg.sv @@
// Package for the omni-wheel speed to PWM block: constants, sine table builder,
// heading fold helper. No dependencies.
package owsp_pkg;

    localparam int TRIG_FRAC_BITS_DEF = 15;
    localparam int TRIG_ENT_W         = 25;  // wide enough for the largest fraction width
    localparam int SPD_W              = 12;
    localparam int DUTY_W             = 16;
    localparam int CFG_IDX_W          = 2;
    localparam int CFG_DATA_W         = 16;
    localparam int WHEEL_W            = 14;  // truncated wheel speed, signed

    localparam logic [CFG_IDX_W-1:0] REG_SPEED_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_TOP      = 2'd1;

    localparam logic [SPD_W-1:0]  OFFSET_RST  = '0;
    localparam logic [DUTY_W-1:0] PWM_TOP_RST = 16'd800;

    localparam logic [15:0] THIRD_Q16  = 16'd21845;
    localparam logic [15:0] ISQRT3_Q16 = 16'd37837;

    localparam longint unsigned PI_Q30 = 64'd3373259426;

    typedef logic [TRIG_ENT_W-1:0] t_trig_ent;
    typedef t_trig_ent t_trig_tbl [0:90];

    typedef struct packed {
        logic [6:0] idx;
        logic       neg;
    } t_fold;

    // Quarter-wave sine table, Taylor series in Q2.30 rounded to frac bits.
    // Each term divides the previous one by (2n)(2n+1); signs alternate.
    function automatic t_trig_tbl owsp_build_tbl(input int frac);
        t_trig_tbl        tbl;
        longint unsigned  x;
        longint unsigned  x2;
        longint unsigned  term;
        longint unsigned  sum;
        for (int k = 0; k <= 90; k++) begin
            x   = (longint'(k) * PI_Q30 + 64'd90) / 64'd180;
            x2  = (x * x + (64'd1 << 29)) >> 30;
            term = x;
            sum  = x;
            term = ((term * x2 + (64'd1 << 29)) >> 30) / 64'd6;
            sum  = sum - term;
            term = ((term * x2 + (64'd1 << 29)) >> 30) / 64'd20;
            sum  = sum + term;
            term = ((term * x2 + (64'd1 << 29)) >> 30) / 64'd42;
            sum  = sum - term;
            term = ((term * x2 + (64'd1 << 29)) >> 30) / 64'd72;
            sum  = sum + term;
            term = ((term * x2 + (64'd1 << 29)) >> 30) / 64'd110;
            sum  = sum - term;
            term = ((term * x2 + (64'd1 << 29)) >> 30) / 64'd156;
            sum  = sum + term;
            term = ((term * x2 + (64'd1 << 29)) >> 30) / 64'd210;
            sum  = sum - term;
            term = ((term * x2 + (64'd1 << 29)) >> 30) / 64'd272;
            sum  = sum + term;
            tbl[k] = TRIG_ENT_W'((sum + (64'd1 << (29 - frac))) >> (30 - frac));
        end
        return tbl;
    endfunction

    // Fold a heading in 0..359 into a quarter-wave index and a sign.
    function automatic t_fold owsp_fold(input logic [8:0] h);
        t_fold f;
        f.neg = 1'b0;
        if (h <= 9'd90) begin
            f.idx = h[6:0];
        end else if (h <= 9'd180) begin
            f.idx = 7'(9'd180 - h);
        end else if (h <= 9'd270) begin
            f.idx = 7'(h - 9'd180);
            f.neg = 1'b1;
        end else begin
            f.idx = 7'(9'd360 - h);
            f.neg = 1'b1;
        end
        return f;
    endfunction

endpackage

@@ rtl/owsp_wheel_cell.sv @@
// One wheel cell: sum, truncate toward zero, offset, direction and saturation.
// Depends on owsp_pkg.
module owsp_wheel_cell
    import owsp_pkg::*;
#(
    parameter int SUM_W = 48,
    parameter int SHIFT = 31
) (
    input  logic                    i_clk,
    input  logic signed [SUM_W-1:0] i_x,
    input  logic signed [SUM_W-1:0] i_y,
    input  logic signed [SUM_W-1:0] i_w,
    input  logic                    i_act,
    input  logic signed [SPD_W-1:0] i_off,
    input  logic [DUTY_W-1:0]       i_top,
    output logic                    o_dir,
    output logic [DUTY_W-1:0]       o_duty
);

    logic signed [SUM_W-1:0]   sum;
    logic signed [SUM_W-1:0]   quo;
    logic signed [WHEEL_W-1:0] n_m;
    logic signed [WHEEL_W-1:0] r_m;
    logic                      r_act;
    logic signed [WHEEL_W:0]   adj;
    logic [WHEEL_W:0]          mag;
    logic [DUTY_W-1:0]         mag_ext;

    // Truncate toward zero: bump a negative quotient when bits were dropped.
    always_comb begin
        sum = i_x + i_y + i_w;
        quo = sum >>> SHIFT;
        if (sum[SUM_W-1] && (|sum[SHIFT-1:0])) begin
            quo = quo + SUM_W'(1);
        end
        n_m = quo[WHEEL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        r_m   <= n_m;
        r_act <= i_act;
    end

    always_comb begin
        adj = {r_m[WHEEL_W-1], r_m};
        if (r_act) begin
            adj = adj - (WHEEL_W+1)'(i_off);
        end
        mag     = adj[WHEEL_W] ? (WHEEL_W+1)'(-adj) : adj;
        mag_ext = DUTY_W'(mag);
    end

    always_ff @(posedge i_clk) begin
        o_dir  <= adj[WHEEL_W];
        o_duty <= (mag_ext > i_top) ? i_top : mag_ext;
    end

endmodule

@@ rtl/omni_wheel_speed_to_pwm.sv @@
// Top level of the three-wheel omni-base inverse kinematics with PWM output.
// Depends on owsp_pkg and owsp_wheel_cell.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+---------------------------------------------
//  command   | start / busy          | i_action i_base_speed i_heading_deg i_spin
//  result    | o_valid (strobe)      | o_dir_* o_duty_* for wheels one..three
//  config    | i_cfg_we              | i_cfg_idx i_cfg_data
//
// A command transfer happens at any edge with start high; busy is always low.
// Each command yields one result (o_valid for one cycle) after these registered
// steps: fold and table lookup, speed times sin/cos, times the Q0.16 constants,
// then two steps in each wheel cell (sum and truncate, offset and saturate).
// One command per cycle sustained.
// Reset clears the stage valid bits and loads speed_offset 0, pwm_top 800.
// The receiver cannot stall, so nothing is held back.
module omni_wheel_speed_to_pwm
    import owsp_pkg::*;
#(
    parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_action,
    input  logic [11:0]           i_base_speed,
    input  logic [8:0]            i_heading_deg,
    input  logic [11:0]           i_spin,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_valid,
    output logic                  o_dir_one,
    output logic [15:0]           o_duty_one,
    output logic                  o_dir_two,
    output logic [15:0]           o_duty_two,
    output logic                  o_dir_three,
    output logic [15:0]           o_duty_three
);

    localparam int TRIG_W = TRIG_FRAC_BITS + 2;   // signed, holds +/-1.0
    localparam int V_W    = SPD_W + TRIG_W;
    localparam int M_W    = V_W + 17;
    localparam int W3_W   = SPD_W + 17;
    localparam int SUM_W  = M_W + 3;
    localparam int SHIFT  = TRIG_FRAC_BITS + 16;
    localparam int LAT    = 5;

    localparam t_trig_tbl SIN_TBL = owsp_build_tbl(TRIG_FRAC_BITS);

    logic                    accept;
    logic [LAT-1:0]          r_vld;
    logic signed [SPD_W-1:0] r_off;
    logic [DUTY_W-1:0]       r_top;

    // stage 1 registers
    logic signed [TRIG_W-1:0] r_sin;
    logic signed [TRIG_W-1:0] r_cos;
    logic signed [SPD_W-1:0]  r_spd1;
    logic signed [SPD_W-1:0]  r_spin1;
    logic                     r_act1;
    // stage 2 registers
    logic signed [V_W-1:0]    r_vx;
    logic signed [V_W-1:0]    r_vyn;
    logic signed [SPD_W-1:0]  r_spin2;
    logic                     r_act2;
    // stage 3 registers
    logic signed [M_W-1:0]    r_vx3;
    logic signed [M_W-1:0]    r_p;
    logic signed [W3_W-1:0]   r_w3;
    logic                     r_act3;

    logic [8:0]               h_mod;
    logic [9:0]               h_cos_raw;
    logic [8:0]               h_cos;
    t_fold                    f_sin;
    t_fold                    f_cos;
    logic [TRIG_W-1:0]        sin_mag;
    logic [TRIG_W-1:0]        cos_mag;

    logic signed [SUM_W-1:0]  vx3_e;
    logic signed [SUM_W-1:0]  p_e;
    logic signed [SUM_W-1:0]  w_e;
    logic signed [SUM_W-1:0]  x_one;
    logic signed [SUM_W-1:0]  y_three;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off <= OFFSET_RST;
            r_top <= PWM_TOP_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_SPEED_OFFSET) begin
                r_off <= i_cfg_data[SPD_W-1:0];
            end else if (i_cfg_idx == REG_PWM_TOP) begin
                r_top <= i_cfg_data[DUTY_W-1:0];
            end
        end
    end

    // Advance the valid marks down the chain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], accept};
        end
    end

    // Stage 1: reduce heading, fold into the quarter wave, read the table.
    always_comb begin
        h_mod     = (i_heading_deg >= 9'd360) ? 9'(i_heading_deg - 9'd360) : i_heading_deg;
        h_cos_raw = {1'b0, h_mod} + 10'd90;
        h_cos     = (h_cos_raw >= 10'd360) ? 9'(h_cos_raw - 10'd360) : h_cos_raw[8:0];
        f_sin     = owsp_fold(h_mod);
        f_cos     = owsp_fold(h_cos);
        sin_mag   = {1'b0, SIN_TBL[f_sin.idx][TRIG_FRAC_BITS:0]};
        cos_mag   = {1'b0, SIN_TBL[f_cos.idx][TRIG_FRAC_BITS:0]};
    end

    always_ff @(posedge i_clk) begin
        r_sin   <= f_sin.neg ? TRIG_W'(-sin_mag) : sin_mag;
        r_cos   <= f_cos.neg ? TRIG_W'(-cos_mag) : cos_mag;
        r_spd1  <= i_base_speed;
        r_spin1 <= i_spin;
        r_act1  <= i_action;
    end

    // Stage 2: Vx and -Vy.
    always_ff @(posedge i_clk) begin
        r_vx    <= r_spd1 * r_sin;
        r_vyn   <= r_spd1 * r_cos;
        r_spin2 <= r_spin1;
        r_act2  <= r_act1;
    end

    // Stage 3: scale by 1/3 and 1/sqrt3.
    always_ff @(posedge i_clk) begin
        r_vx3  <= r_vx * $signed({1'b0, THIRD_Q16});
        r_p    <= r_vyn * $signed({1'b0, ISQRT3_Q16});
        r_w3   <= r_spin2 * $signed({1'b0, THIRD_Q16});
        r_act3 <= r_act2;
    end

    // Wheel operands; r_p is -Vy/sqrt3 in sum scale.
    always_comb begin
        vx3_e   = SUM_W'(r_vx3);
        p_e     = SUM_W'(r_p);
        w_e     = SUM_W'(r_w3) <<< TRIG_FRAC_BITS;
        x_one   = -(vx3_e <<< 1);
        y_three = -p_e;
    end

    owsp_wheel_cell #(.SUM_W(SUM_W), .SHIFT(SHIFT)) u_wheel_one (
        .i_clk  (i_clk),
        .i_x    (x_one),
        .i_y    ('0),
        .i_w    (w_e),
        .i_act  (r_act3),
        .i_off  (r_off),
        .i_top  (r_top),
        .o_dir  (o_dir_one),
        .o_duty (o_duty_one)
    );

    owsp_wheel_cell #(.SUM_W(SUM_W), .SHIFT(SHIFT)) u_wheel_two (
        .i_clk  (i_clk),
        .i_x    (vx3_e),
        .i_y    (p_e),
        .i_w    (w_e),
        .i_act  (r_act3),
        .i_off  (r_off),
        .i_top  (r_top),
        .o_dir  (o_dir_two),
        .o_duty (o_duty_two)
    );

    owsp_wheel_cell #(.SUM_W(SUM_W), .SHIFT(SHIFT)) u_wheel_three (
        .i_clk  (i_clk),
        .i_x    (vx3_e),
        .i_y    (y_three),
        .i_w    (w_e),
        .i_act  (r_act3),
        .i_off  (r_off),
        .i_top  (r_top),
        .o_dir  (o_dir_three),
        .o_duty (o_duty_three)
    );

    assign o_valid = r_vld[LAT-1];

`ifndef SYNTHESIS
    a_result_has_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT))
        else $error("result strobe without a command transfer");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

    a_command_yields_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LAT (o_valid || !$past(i_rst_n, 1) || !$past(i_rst_n, 2)
            || !$past(i_rst_n, 3) || !$past(i_rst_n, 4)))
        else $error("command transfer lost in the pipeline");
`endif

endmodule

@@ tb/sv/tb_top.sv @@
// Testbench for omni_wheel_speed_to_pwm: directed and random motion commands,
// several register settings, and a self-checking kinematics predictor.
// Depends on owsp_pkg and the omni_wheel_speed_to_pwm RTL.
module tb_top;
    import owsp_pkg::*;

    typedef struct {
        logic        action;
        logic [11:0] speed;
        logic [8:0]  heading;
        logic [11:0] spin;
        int          gap;
    } t_cmd;

    typedef struct {
        logic        dir_one;
        logic [15:0] duty_one;
        logic        dir_two;
        logic [15:0] duty_two;
        logic        dir_three;
        logic [15:0] duty_three;
    } t_wheels;

    localparam int FRAC = 15;
    localparam int SUM_SHIFT = FRAC + 16;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_action = 1'b0;
    logic [11:0] i_base_speed = '0;
    logic [8:0]  i_heading_deg = '0;
    logic [11:0] i_spin = '0;
    logic        i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic        o_valid;
    logic        o_dir_one, o_dir_two, o_dir_three;
    logic [15:0] o_duty_one, o_duty_two, o_duty_three;

    t_cmd    cmd_q[$];
    t_wheels wheel_q[$];
    longint  sine_tbl [0:90];
    longint  offset_reg;
    longint  top_reg;
    int      mismatches = 0;
    int      gap_left = 0;
    bit      no_idle = 1'b0;
    bit      taken = 1'b0;

    omni_wheel_speed_to_pwm i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_action(i_action), .i_base_speed(i_base_speed),
        .i_heading_deg(i_heading_deg), .i_spin(i_spin),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid),
        .o_dir_one(o_dir_one), .o_duty_one(o_duty_one),
        .o_dir_two(o_dir_two), .o_duty_two(o_duty_two),
        .o_dir_three(o_dir_three), .o_duty_three(o_duty_three)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Quarter-wave sine by an integer Taylor series in Q2.30, rounded to FRAC bits.
    function automatic longint quarter_sine(input int k);
        longint unsigned x, x2, term, acc;
        x = (longint'(k) * PI_Q30 + 64'd90) / 64'd180;
        x2 = (x * x + (64'd1 << 29)) >> 30;
        term = x;
        acc = x;
        for (int n = 1; n <= 8; n++) begin
            term = ((term * x2 + (64'd1 << 29)) >> 30) / longint'((2 * n) * (2 * n + 1));
            acc = (n % 2 == 1) ? acc - term : acc + term;
        end
        return longint'((acc + (64'd1 << (29 - FRAC))) >> (30 - FRAC));
    endfunction

    function automatic longint sine_of(input int h);
        h = h % 360;
        if (h <= 90) return sine_tbl[h];
        if (h <= 180) return sine_tbl[180 - h];
        if (h <= 270) return -sine_tbl[h - 180];
        return -sine_tbl[360 - h];
    endfunction

    function automatic longint chop(input longint v);
        return (v < 0) ? -((-v) >>> SUM_SHIFT) : (v >>> SUM_SHIFT);
    endfunction

    function automatic void to_pwm(input longint m, output logic dir, output logic [15:0] duty);
        longint mag;
        mag = (m < 0) ? -m : m;
        dir = (m < 0);
        if (mag > top_reg) mag = top_reg;
        duty = mag[15:0];
    endfunction

    // Inverse kinematics of one command under the current register copy.
    function automatic t_wheels wheel_speeds(input logic act, input logic [11:0] spd_raw,
                                             input logic [8:0] hd, input logic [11:0] spn_raw);
        t_wheels r;
        longint spd, spn, vx, vy, w3, vx3, vys, m1, m2, m3;
        spd = longint'($signed(spd_raw));
        spn = longint'($signed(spn_raw));
        vx = spd * sine_of(int'(hd));
        vy = -(spd * sine_of(int'(hd) + 90));
        w3 = spn * longint'(THIRD_Q16) * (64'sd1 <<< FRAC);
        vx3 = vx * longint'(THIRD_Q16);
        vys = vy * longint'(ISQRT3_Q16);
        m1 = chop(-2 * vx3 + w3);
        m2 = chop(vx3 - vys + w3);
        m3 = chop(vx3 + vys + w3);
        if (act) begin
            m1 -= offset_reg;
            m2 -= offset_reg;
            m3 -= offset_reg;
        end
        to_pwm(m1, r.dir_one, r.duty_one);
        to_pwm(m2, r.dir_two, r.duty_two);
        to_pwm(m3, r.dir_three, r.duty_three);
        return r;
    endfunction

    // Driver: hold a command until its transfer, then advance after its gap.
    always @(negedge i_clk) begin
        t_cmd c;
        if (i_rst_n && !(start && !taken)) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end else if (cmd_q.size() > 0) begin
                c = cmd_q.pop_front();
                start <= 1'b1;
                i_action <= c.action;
                i_base_speed <= c.speed;
                i_heading_deg <= c.heading;
                i_spin <= c.spin;
                gap_left <= c.gap;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: predict at each command transfer, check each result strobe.
    always @(posedge i_clk) begin
        t_wheels want;
        taken <= i_rst_n && start && !busy;
        if (i_rst_n && start && !busy)
            wheel_q.push_back(wheel_speeds(i_action, i_base_speed, i_heading_deg, i_spin));
        if (i_rst_n && o_valid) begin
            if (wheel_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transfer");
            end else begin
                want = wheel_q.pop_front();
                if (want.dir_one !== o_dir_one || want.duty_one !== o_duty_one ||
                    want.dir_two !== o_dir_two || want.duty_two !== o_duty_two ||
                    want.dir_three !== o_dir_three || want.duty_three !== o_duty_three) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %0d/%0d %0d/%0d %0d/%0d got %0d/%0d %0d/%0d %0d/%0d",
                                 want.dir_one, want.duty_one, want.dir_two, want.duty_two,
                                 want.dir_three, want.duty_three, o_dir_one, o_duty_one,
                                 o_dir_two, o_duty_two, o_dir_three, o_duty_three);
                end
            end
        end
    end

    task automatic add_cmd(input logic act, input logic [11:0] spd, input int hd,
                           input logic [11:0] spn);
        t_cmd c;
        c.action = act;
        c.speed = spd;
        c.heading = 9'(hd);
        c.spin = spn;
        c.gap = no_idle ? 0 : $urandom_range(0, 6);
        cmd_q.push_back(c);
    endtask

    task automatic drain();
        while (cmd_q.size() > 0 || start || wheel_q.size() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        if (idx == REG_SPEED_OFFSET) offset_reg = longint'($signed(val[11:0]));
        else if (idx == REG_PWM_TOP) top_reg = longint'(val);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_batch(input int n);
        for (int i = 0; i < n; i++) begin
            if (i % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
            add_cmd(1'($urandom_range(0, 1)), 12'($urandom), $urandom_range(0, 359),
                    ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 6)) : 12'($urandom));
        end
        drain();
    endtask

    initial begin
        int hd_list[12] = '{0, 1, 45, 89, 90, 91, 179, 180, 181, 270, 300, 359};
        for (int k = 0; k <= 90; k++) sine_tbl[k] = quarter_sine(k);
        offset_reg = 0;
        top_reg = 800;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: heading corners, speed and spin extremes, spin of three
        for (int i = 0; i < 12; i++)
            add_cmd(1'(i % 2), (i % 3 == 0) ? 12'h800 : 12'h7ff, hd_list[i], 12'd0);
        add_cmd(1'b0, 12'd0, 0, 12'd3);
        add_cmd(1'b0, 12'd0, 256, 12'h800);
        add_cmd(1'b1, 12'd0, 0, 12'h7ff);
        add_cmd(1'b0, 12'hfff, 359, 12'hffd);
        add_cmd(1'b1, 12'h800, 270, 12'h800);
        add_cmd(1'b0, 12'h7ff, 90, 12'h7ff);
        drain();
        random_batch(100);

        // Extreme offset and widest top, plus writes to unused indexes
        write_reg(REG_SPEED_OFFSET, 16'h0800);
        write_reg(REG_PWM_TOP, 16'hffff);
        write_reg(2'd2, 16'h1234);
        write_reg(2'd3, 16'hffff);
        add_cmd(1'b1, 12'h7ff, 90, 12'h7ff);
        add_cmd(1'b1, 12'h800, 270, 12'h800);
        random_batch(150);

        write_reg(REG_SPEED_OFFSET, 16'h07ff);
        write_reg(REG_PWM_TOP, 16'd1);
        random_batch(120);

        for (int p = 0; p < 3; p++) begin
            write_reg(REG_SPEED_OFFSET, 16'($urandom));
            write_reg(REG_PWM_TOP, 16'($urandom_range(1, 3000)));
            random_batch(80);
        end

        if (mismatches == 0 && wheel_q.size() == 0) begin
            $display("omni_wheel_speed_to_pwm verification clean");
        end else begin
            $display("omni_wheel_speed_to_pwm verification failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("omni_wheel_speed_to_pwm verification failed");
        $finish;
    end

endmodule
